### hdl/rcsv_pkg.sv
package rcsv_pkg;

	localparam int DATA_W  = 8;
	localparam int SADDR_W = 8;
	localparam int THR_W   = 3;

	typedef logic [DATA_W-1:0]  data_t;
	typedef logic [SADDR_W-1:0] saddr_t;
	typedef logic [THR_W-1:0]   thr_t;

	// request opcodes
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam thr_t THR_RESET = 3'd3;

endpackage

### hdl/redundant_copy_store_vote.sv
// One request is served at a time: the address is folded into the store, each copy is read
// or written in turn, then done is raised; busy is high from acceptance until done. This is
// set by the single port of the store, which makes one access per cycle; a new request is
// taken in the cycle done is high.
// Reset: arst_n clears control and sets agree_threshold to 3, then a clearing pass writes
// zero to every cell with busy high; the receiver cannot stall done.
module redundant_copy_store_vote #(
	parameter int STORE_DEPTH = 256,
	parameter int COPIES      = 5
) (
	input  logic            clk,
	input  logic            arst_n,
	// request channel
	input  logic            start,
	output logic            busy,
	input  logic            opcode,
	input  rcsv_pkg::saddr_t start_address,
	input  rcsv_pkg::data_t  write_value,
	// agreement threshold register
	input  logic            agree_threshold_we,
	input  rcsv_pkg::thr_t   agree_threshold,
	// result strobe
	output logic            done,
	output rcsv_pkg::data_t  read_value,
	output logic            vote_error
);

	import rcsv_pkg::*;

	localparam int AW   = $clog2(STORE_DEPTH);
	localparam int PW   = (AW > SADDR_W) ? AW : SADDR_W;
	localparam int CNTW = $clog2(COPIES);
	localparam int SUMW = $clog2(COPIES + 1);
	localparam int CMPW = (SUMW > THR_W) ? SUMW : THR_W;

	localparam logic [PW:0]     DEPTH_X  = (PW+1)'(STORE_DEPTH);
	localparam logic [PW-1:0]   LAST_PTR = PW'(STORE_DEPTH - 1);
	localparam logic [AW-1:0]   LAST_CLR = AW'(STORE_DEPTH - 1);
	localparam logic [CNTW-1:0] LAST_CNT = CNTW'(COPIES - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_REDUCE,
		ST_ACCESS,
		ST_DONE
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   clr_q;
	logic [PW-1:0]   ptr_q;
	logic [CNTW-1:0] cnt_q;
	logic            op_q;
	data_t           wval_q;
	thr_t            thr_q;

	// copies seen before the reference, which is read last
	data_t           copy_q [COPIES-1];

	// single-port store
	data_t           mem [STORE_DEPTH];
	data_t           mem_rdata;
	logic            mem_we;
	logic [AW-1:0]   mem_addr;
	data_t           mem_wdata;

	logic            accept;
	logic            ptr_ge_depth;
	logic [SUMW-1:0] match_cnt;
	logic            vote_pass;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// start_address may lie beyond a small store: fold it down one subtract per cycle
	assign ptr_ge_depth = ({1'b0, ptr_q} >= DEPTH_X);

	// Clearing pass owns the port after reset; otherwise walk the group of copies.
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = ptr_q[AW-1:0];
		mem_wdata = wval_q;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_addr  = clr_q;
			mem_wdata = '0;
		end else if (state_q == ST_ACCESS && op_q == OP_WRITE) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end else begin
			mem_rdata <= mem[mem_addr];
		end
	end

	// Shift each returning copy in; the last one to arrive is the reference.
	always_ff @(posedge clk) begin
		if (state_q == ST_ACCESS && op_q == OP_READ && cnt_q != '0) begin
			copy_q[0] <= mem_rdata;
			for (int i = 1; i < COPIES - 1; i++) begin
				copy_q[i] <= copy_q[i-1];
			end
		end
	end

	// Count matches against the reference, the reference itself included.
	always_comb begin
		match_cnt = SUMW'(1);
		for (int i = 0; i < COPIES - 1; i++) begin
			if (copy_q[i] == mem_rdata) begin
				match_cnt = match_cnt + SUMW'(1);
			end
		end
	end

	assign vote_pass = (CMPW'(match_cnt) >= CMPW'(thr_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (agree_threshold_we) begin
			thr_q <= agree_threshold;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			ptr_q      <= '0;
			cnt_q      <= '0;
			op_q       <= OP_READ;
			wval_q     <= '0;
			done       <= 1'b0;
			read_value <= '0;
			vote_error <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_CLR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						ptr_q   <= PW'(start_address);
						cnt_q   <= '0;
						op_q    <= opcode;
						wval_q  <= write_value;
						state_q <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					if (ptr_ge_depth) begin
						ptr_q <= PW'({1'b0, ptr_q} - DEPTH_X);
					end else begin
						state_q <= ST_ACCESS;
					end
				end
				ST_ACCESS: begin
					// advance to the next cell, wrapping at the top of the store
					ptr_q <= (ptr_q == LAST_PTR) ? '0 : ptr_q + PW'(1);
					cnt_q <= cnt_q + CNTW'(1);
					if (cnt_q == LAST_CNT) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
					if (op_q == OP_WRITE) begin
						read_value <= '0;
						vote_error <= 1'b0;
					end else if (vote_pass) begin
						read_value <= mem_rdata;
						vote_error <= 1'b0;
					end else begin
						read_value <= '0;
						vote_error <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_done_after_vote: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_DONE)
		else $error("done without a finished request");

	a_error_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && vote_error) |-> read_value == '0)
		else $error("failed vote returned a nonzero value");

	a_accept_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy low after an accepted request");

	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACCESS) |-> !ptr_ge_depth)
		else $error("cell pointer beyond the store");
`endif

endmodule
